// ===== rtl/core/ihrc_pkg.sv =====
// Shared types, constants and a helper function for the IPv4 header receive check.
package ihrc_pkg;

    localparam int unsigned POS_W = 5;
    localparam logic [POS_W-1:0] HDR_BYTES = 5'd20;
    localparam logic [POS_W-1:0] LAST_POS = 5'd19;
    localparam logic [POS_W-1:0] TTL_POS = 5'd8;
    localparam logic [POS_W-1:0] ADDR_POS = 5'd16;
    localparam logic [3:0] CSUM_WORD = 4'd5;
    localparam logic [3:0] IP_VERSION = 4'd4;
    localparam logic [3:0] IP_IHL = 4'd5;
    localparam logic [15:0] ALL_ONES = 16'hffff;

    localparam logic [2:0] VERDICT_ACCEPT = 3'd0;
    localparam logic [2:0] VERDICT_VERSION = 3'd1;
    localparam logic [2:0] VERDICT_LENGTH = 3'd2;
    localparam logic [2:0] VERDICT_TTL = 3'd3;
    localparam logic [2:0] VERDICT_DEST = 3'd4;
    localparam logic [2:0] VERDICT_CSUM = 3'd5;

    typedef struct packed {
        logic [7:0]       data;
        logic [POS_W-1:0] pos;
    } hdr_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            ones_add = s[15:0] + {15'd0, s[16]};
        end
    endfunction

endpackage

// ===== rtl/core/ihrc_front.sv =====
// Front end: accepts bytes, tracks the header position and forwards header bytes only.
module ihrc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [7:0]          packet_byte,
    input  logic                first_byte,
    output logic                push,
    output ihrc_pkg::hdr_entry_t push_entry
);
    import ihrc_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] cur_pos;
    logic             in_header;
    logic             take;

    assign take      = in_valid && in_ready;
    assign cur_pos   = first_byte ? '0 : pos_reg;
    assign in_header = cur_pos < HDR_BYTES;
    assign push      = take && in_header;

    always_comb
    begin
        push_entry.data = packet_byte;
        push_entry.pos  = cur_pos;
        pos_next        = pos_reg;
        if (push)
        begin
            pos_next = cur_pos + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= HDR_BYTES;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

endmodule

// ===== rtl/core/ihrc_fifo.sv =====
// Short queue of header bytes between the front and back ends.
module ihrc_fifo #(
    parameter int unsigned DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ihrc_pkg::hdr_entry_t push_entry,
    input  logic                 pop,
    output ihrc_pkg::hdr_entry_t head_entry,
    output ihrc_pkg::fifo_status_t status
);
    import ihrc_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    hdr_entry_t       slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    assign status.full  = count_reg == FULL_COUNT;
    assign status.empty = count_reg == '0;
    assign head_entry   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // The fill count never exceeds the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("queue count above depth");

    // The front end never writes into a full queue unless a slot frees up.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        status.full && !pop |-> !push)
        else $error("push into full queue");

    // A pop without a push drops the count by exactly one.
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count not decremented on pop");

endmodule

// ===== rtl/core/ihrc_back.sv =====
// Back end: runs the header checks and checksum and holds the verdict register.
module ihrc_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [31:0]           local_address,
    input  ihrc_pkg::hdr_entry_t  head_entry,
    input  ihrc_pkg::fifo_status_t status,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            verdict
);
    import ihrc_pkg::*;

    logic [31:0] addr_reg;
    logic [15:0] sum_reg;
    logic [15:0] sum_next;
    logic [7:0]  held_reg;
    logic [7:0]  held_next;
    logic [15:0] csum_reg;
    logic [15:0] csum_next;
    logic        ver_bad_reg;
    logic        ver_bad_next;
    logic        len_bad_reg;
    logic        len_bad_next;
    logic        ttl_zero_reg;
    logic        ttl_zero_next;
    logic        addr_bad_reg;
    logic        addr_bad_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [2:0]  verdict_reg;
    logic [2:0]  verdict_next;
    logic [7:0]  want_byte;
    logic [15:0] word;
    logic        is_first;
    logic        is_last;
    logic        slot_free;

    assign is_first  = head_entry.pos == '0;
    assign is_last   = head_entry.pos == LAST_POS;
    assign slot_free = !out_valid_reg || out_ready;
    assign pop       = !status.empty && (!is_last || slot_free);
    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;
    assign word      = {held_reg, head_entry.data};

    always_comb
    begin
        case (head_entry.pos[1:0])
            2'd0:    want_byte = addr_reg[31:24];
            2'd1:    want_byte = addr_reg[23:16];
            2'd2:    want_byte = addr_reg[15:8];
            default: want_byte = addr_reg[7:0];
        endcase
    end

    always_comb
    begin
        sum_next      = is_first ? '0 : sum_reg;
        csum_next     = is_first ? '0 : csum_reg;
        held_next     = held_reg;
        ver_bad_next  = is_first ? 1'b0 : ver_bad_reg;
        len_bad_next  = is_first ? 1'b0 : len_bad_reg;
        ttl_zero_next = is_first ? 1'b0 : ttl_zero_reg;
        addr_bad_next = is_first ? 1'b0 : addr_bad_reg;
        if (is_first)
        begin
            ver_bad_next = head_entry.data[7:4] != IP_VERSION;
            len_bad_next = head_entry.data[3:0] != IP_IHL;
        end
        if (head_entry.pos == TTL_POS && head_entry.data == '0)
        begin
            ttl_zero_next = 1'b1;
        end
        if (head_entry.pos >= ADDR_POS && want_byte != head_entry.data)
        begin
            addr_bad_next = 1'b1;
        end
        if (!head_entry.pos[0])
        begin
            held_next = head_entry.data;
        end
        else if (head_entry.pos[4:1] == CSUM_WORD)
        begin
            csum_next = word;
        end
        else
        begin
            sum_next = ones_add(sum_next, word);
        end

        if (ver_bad_next)
            verdict_next = VERDICT_VERSION;
        else if (len_bad_next)
            verdict_next = VERDICT_LENGTH;
        else if (ttl_zero_next)
            verdict_next = VERDICT_TTL;
        else if (addr_bad_next)
            verdict_next = VERDICT_DEST;
        else if (csum_next != (ALL_ONES - sum_next))
            verdict_next = VERDICT_CSUM;
        else
            verdict_next = VERDICT_ACCEPT;

        out_valid_next = out_valid_reg && !out_ready;
        if (pop && is_last)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            sum_reg       <= '0;
            held_reg      <= '0;
            csum_reg      <= '0;
            ver_bad_reg   <= 1'b0;
            len_bad_reg   <= 1'b0;
            ttl_zero_reg  <= 1'b0;
            addr_bad_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                addr_reg <= local_address;
            end
            if (pop)
            begin
                sum_reg      <= sum_next;
                held_reg     <= held_next;
                csum_reg     <= csum_next;
                ver_bad_reg  <= ver_bad_next;
                len_bad_reg  <= len_bad_next;
                ttl_zero_reg <= ttl_zero_next;
                addr_bad_reg <= addr_bad_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && is_last)
        begin
            verdict_reg <= verdict_next;
        end
    end

    // Retiring the last header byte always leaves a verdict pending.
    a_last_gives_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        pop && is_last |=> out_valid_reg)
        else $error("last header byte retired without a verdict");

endmodule

// ===== rtl/core/ipv4_header_receive_check.sv =====
// Top level of the IPv4 header receive check: front end, byte queue and back end.
//
// The block takes an IPv4 packet one byte per transfer on the input channel
// (packet_byte with first_byte marking the first byte of a packet) and gives
// one verdict transfer per complete 20-byte header on the output channel:
// 0 accept, 1 bad version, 2 bad header length, 3 TTL zero, 4 destination
// mismatch, 5 checksum error. Payload bytes and bytes after a verdict are
// dropped without a result until the next first_byte; a first_byte in the
// middle of a header restarts the check.
// The configuration channel carries local_address; cfg_ready is always high.
// Throughput is one byte per cycle while in_ready is high. The front end sets
// the header position in the cycle of the transfer; the back end retires one
// queued byte per cycle, unless it stops at a last byte, with a single 16-bit
// end-around-carry add. The verdict is registered once the back end retires the
// 20th header byte from the queue, unless an old verdict waits for the receiver.
// While out_ready is low a pending verdict holds; the back end then stops at
// the last byte of the next header, and once the queue of QUEUE_DEPTH bytes
// fills, in_ready drops. After reset the block waits for a first_byte,
// the queue is empty, no verdict is pending and local_address is zero.
module ipv4_header_receive_check #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  packet_byte,
    input  logic        first_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  verdict,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] local_address
);
    import ihrc_pkg::*;

    logic         push;
    logic         pop;
    hdr_entry_t   push_entry;
    hdr_entry_t   head_entry;
    fifo_status_t status;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;
    // A byte is taken whenever the queue has room, even while a verdict waits.
    assign in_ready  = !status.full;

    ihrc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .packet_byte (packet_byte),
        .first_byte  (first_byte),
        .push        (push),
        .push_entry  (push_entry)
    );

    ihrc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .status     (status)
    );

    ihrc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .local_address (local_address),
        .head_entry    (head_entry),
        .status        (status),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .verdict       (verdict)
    );

endmodule
